### hw/rtl/equirectangular_projection_macros.svh
// Assertion macros for the equirectangular projection checker.
// Each macro expects clk and rst in the scope where it is used.
`ifndef EQUIRECTANGULAR_PROJECTION_MACROS_SVH
`define EQUIRECTANGULAR_PROJECTION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ERP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("equirectangular projection check failed");

// Next-cycle implication, disabled during reset.
`define ERP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("equirectangular projection check failed");

// Next-cycle implication that also holds across reset.
`define ERP_ASSERT_NXT_NR(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("equirectangular projection check failed");

`endif

### hw/rtl/erp_pkg.sv
// Package for the equirectangular projection block: widths, constants,
// CORDIC arctangent table, stage types and the CORDIC step function.
// No dependencies.
package erp_pkg;

  localparam int COORD_WIDTH_DEF   = 24;
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int TABLE_LEN         = 30;

  localparam int XY_W    = 37;
  localparam int ANG_W   = 34;
  localparam int W_WIDTH = 14;
  localparam int H_WIDTH = 13;
  localparam int OUT_W   = 22;
  localparam int U_W     = 33;
  localparam int V_W     = 32;
  localparam int PX_W    = W_WIDTH + U_W;
  localparam int PY_W    = H_WIDTH + V_W;
  localparam int PX_SH   = 24;
  localparam int PY_SH   = 23;
  localparam int PXF_W   = PX_W + 1 - PX_SH;
  localparam int PYF_W   = PY_W + 1 - PY_SH;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [W_WIDTH-1:0] W_RESET = W_WIDTH'(2048);
  localparam logic [H_WIDTH-1:0] H_RESET = H_WIDTH'(1024);

  localparam logic [30:0]      GAIN_Q30 = 31'd1768195363;
  localparam logic [OUT_W-1:0] OUT_MAX  = '1;

  localparam logic [ANG_W-1:0] ANG_QUARTER = ANG_W'(64'd1 << 30);
  localparam logic [ANG_W:0]   U_OFFSET    = (ANG_W+1)'(64'd1 << 31);
  localparam logic [ANG_W:0]   U_LIMIT     = (ANG_W+1)'(64'd1 << 32);
  localparam logic [ANG_W:0]   V_OFFSET    = (ANG_W+1)'(64'd1 << 30);
  localparam logic [ANG_W:0]   V_LIMIT     = (ANG_W+1)'(64'd1 << 31);

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [0:0] {
    REG_TEXTURE_WIDTH,
    REG_TEXTURE_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic signed [XY_W-1:0] py;
    logic                   deg;
    logic                   xz0;
  } p1_side_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] phi;
    logic                    deg;
  } p2_side_t;

  typedef struct packed {
    logic [OUT_W-1:0] px;
    logic [OUT_W-1:0] py;
    logic             deg;
  } pixel_t;

  function automatic cordic_t cordic_step(cordic_t s, int i);
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic [ANG_W-1:0]       a;
    cordic_t                r;
    dx = s.y >>> i;
    dy = s.x >>> i;
    a  = ANG_W'(ATAN_TAB[i]);
    if (!s.y[XY_W-1]) begin
      r.x   = s.x + dx;
      r.y   = s.y - dy;
      r.ang = s.ang + a;
    end else begin
      r.x   = s.x - dx;
      r.y   = s.y + dy;
      r.ang = s.ang - a;
    end
    return r;
  endfunction

endpackage

### hw/rtl/erp_stream_if.sv
// Stream interfaces for the equirectangular projection block:
// bearing input channel and pixel result channel. Depends on erp_pkg.
interface erp_bearing_if #(
  parameter int COORD_WIDTH = erp_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] bearing_x;
  logic signed [COORD_WIDTH-1:0] bearing_y;
  logic signed [COORD_WIDTH-1:0] bearing_z;

  modport source (output valid, bearing_x, bearing_y, bearing_z, input ready);
  modport sink (input valid, bearing_x, bearing_y, bearing_z, output ready);
endinterface

interface erp_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [erp_pkg::OUT_W-1:0]   pixel_x;
  logic [erp_pkg::OUT_W-1:0]   pixel_y;
  logic                        degenerate;

  modport source (output valid, pixel_x, pixel_y, degenerate, input ready);
  modport sink (input valid, pixel_x, pixel_y, degenerate, output ready);
endinterface

### hw/rtl/equirectangular_projection.sv
// Equirectangular projection: maps a signed Q8.16 bearing vector to an
// unsigned Q14.8 panorama pixel. Depends on erp_pkg and erp_stream_if.
//
// The block takes one bearing per clock while it is not stalled and returns
// one pixel per bearing, in order. It has one input register, one
// pre-rotation/multiply stage, one register per CORDIC iteration for
// longitude and again for latitude, an angle offset/clamp stage, an
// image-size scaling stage and the output register. Each stage holds its
// item when the next one is full and cannot advance, so bubbles close up
// and a waiting result stalls new input only once every stage holds an item.
// An all-zero bearing gives zero coordinates with degenerate set. Width and
// height sit at byte addresses 0 and 4 of the APB port and must be written
// only while the pipeline is empty; the block itself does not enforce this.
module equirectangular_projection #(
  parameter int COORD_WIDTH   = erp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = erp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  erp_bearing_if.sink                  bearing,
  erp_pixel_if.source                  pixel,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [erp_pkg::ADDR_W-1:0]   paddr,
  input  logic [erp_pkg::DATA_W-1:0]   pwdata,
  output logic [erp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import erp_pkg::*;

  localparam int SHIFT = 32 - COORD_WIDTH;
  localparam int S_IN  = 0;
  localparam int S_PRE = 1;
  localparam int S_P1  = 2;
  localparam int S_P2  = S_P1 + CORDIC_STAGES;
  localparam int S_SA  = S_P2 + CORDIC_STAGES;
  localparam int S_SB  = S_SA + 1;
  localparam int LAST  = S_SB + 1;

  // Configuration registers
  logic [W_WIDTH-1:0] width_q;
  logic [H_WIDTH-1:0] height_q;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= W_RESET;
      height_q <= H_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[ADDR_W-1]))
        REG_TEXTURE_WIDTH:  width_q  <= pwdata[W_WIDTH-1:0];
        REG_TEXTURE_HEIGHT: height_q <= pwdata[H_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1]))
      REG_TEXTURE_WIDTH:  prdata = DATA_W'(width_q);
      REG_TEXTURE_HEIGHT: prdata = DATA_W'(height_q);
      default:            prdata = '0;
    endcase
  end

  // Stage valids and per-stage advance
  logic [LAST:0]   vld;
  logic [LAST:0]   vld_in;
  logic [LAST+1:0] en;

  assign en[LAST+1] = pixel.ready;
  assign vld_in     = {vld[LAST-1:0], bearing.valid};

  for (genvar k = 0; k <= LAST; k++) begin : g_en
    assign en[k] = ~vld[k] | en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k <= LAST; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign bearing.ready = en[S_IN];

  // Input register
  logic signed [31:0] xs_q, ys_q, zs_q;

  always_ff @(posedge clk) begin
    if (en[S_IN]) begin
      xs_q <= 32'(bearing.bearing_x) <<< SHIFT;
      ys_q <= 32'(bearing.bearing_y) <<< SHIFT;
      zs_q <= 32'(bearing.bearing_z) <<< SHIFT;
    end
  end

  // Pre-rotation and scaled latitude input
  cordic_t            pre_next, pre_q;
  p1_side_t           pre_side_next, pre_side_q;
  logic signed [XY_W-1:0] xe, ze;
  logic signed [32:0]     negy;
  logic signed [64:0]     prod;

  always_comb begin
    xe   = XY_W'(xs_q);
    ze   = XY_W'(zs_q);
    negy = -(33'(ys_q));
    prod = negy * $signed({1'b0, GAIN_Q30});
    if (zs_q[31]) begin
      if (!xs_q[31]) begin
        pre_next.x   = xe;
        pre_next.y   = -ze;
        pre_next.ang = ANG_QUARTER;
      end else begin
        pre_next.x   = -xe;
        pre_next.y   = ze;
        pre_next.ang = -ANG_QUARTER;
      end
    end else begin
      pre_next.x   = ze;
      pre_next.y   = xe;
      pre_next.ang = '0;
    end
    pre_side_next.py  = XY_W'(prod >>> 30);
    pre_side_next.deg = (xs_q == '0) && (ys_q == '0) && (zs_q == '0);
    pre_side_next.xz0 = (xs_q == '0) && (zs_q == '0);
  end

  always_ff @(posedge clk) begin
    if (en[S_PRE]) begin
      pre_q      <= pre_next;
      pre_side_q <= pre_side_next;
    end
  end

  // Longitude CORDIC
  cordic_t  p1_q  [CORDIC_STAGES];
  p1_side_t p1s_q [CORDIC_STAGES];

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_p1
    cordic_t  src;
    p1_side_t src_side;
    if (j == 0) begin : g_first
      assign src      = pre_q;
      assign src_side = pre_side_q;
    end else begin : g_rest
      assign src      = p1_q[j-1];
      assign src_side = p1s_q[j-1];
    end
    always_ff @(posedge clk) begin
      if (en[S_P1+j]) begin
        p1_q[j]  <= cordic_step(src, j);
        p1s_q[j] <= src_side;
      end
    end
  end

  // Latitude CORDIC
  cordic_t  p2_init;
  p2_side_t p2_side_init;
  cordic_t  p2_q  [CORDIC_STAGES];
  p2_side_t p2s_q [CORDIC_STAGES];

  always_comb begin
    p2_init.x        = p1s_q[CORDIC_STAGES-1].xz0 ? '0 : p1_q[CORDIC_STAGES-1].x;
    p2_init.y        = p1s_q[CORDIC_STAGES-1].py;
    p2_init.ang      = '0;
    p2_side_init.phi = p1s_q[CORDIC_STAGES-1].xz0 ? '0 : p1_q[CORDIC_STAGES-1].ang;
    p2_side_init.deg = p1s_q[CORDIC_STAGES-1].deg;
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_p2
    cordic_t  src;
    p2_side_t src_side;
    if (j == 0) begin : g_first
      assign src      = p2_init;
      assign src_side = p2_side_init;
    end else begin : g_rest
      assign src      = p2_q[j-1];
      assign src_side = p2s_q[j-1];
    end
    always_ff @(posedge clk) begin
      if (en[S_P2+j]) begin
        p2_q[j]  <= cordic_step(src, j);
        p2s_q[j] <= src_side;
      end
    end
  end

  // Angle offset and clamp
  logic signed [ANG_W:0] u_s, v_s;
  logic [U_W-1:0]        u_next, u_q;
  logic [V_W-1:0]        v_next, v_q;
  logic                  deg_a_q;

  always_comb begin
    u_s = (ANG_W+1)'(p2s_q[CORDIC_STAGES-1].phi) + U_OFFSET;
    v_s = V_OFFSET - (ANG_W+1)'(p2_q[CORDIC_STAGES-1].ang);
    if (u_s[ANG_W]) begin
      u_next = '0;
    end else if (u_s > U_LIMIT) begin
      u_next = U_W'(U_LIMIT);
    end else begin
      u_next = U_W'(u_s);
    end
    if (v_s[ANG_W]) begin
      v_next = '0;
    end else if (v_s > V_LIMIT) begin
      v_next = V_W'(V_LIMIT);
    end else begin
      v_next = V_W'(v_s);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SA]) begin
      u_q     <= u_next;
      v_q     <= v_next;
      deg_a_q <= p2s_q[CORDIC_STAGES-1].deg;
    end
  end

  // Scale by image size
  logic [PX_W-1:0] prodx_q;
  logic [PY_W-1:0] prody_q;
  logic            deg_b_q;

  always_ff @(posedge clk) begin
    if (en[S_SB]) begin
      prodx_q <= PX_W'(width_q) * PX_W'(u_q);
      prody_q <= PY_W'(height_q) * PY_W'(v_q);
      deg_b_q <= deg_a_q;
    end
  end

  // Round, clamp and register the result
  logic [PX_W:0]      sumx;
  logic [PY_W:0]      sumy;
  logic [PXF_W-1:0]   pxf;
  logic [PYF_W-1:0]   pyf;
  pixel_t             out_next, out_q;

  always_comb begin
    sumx = (PX_W+1)'(prodx_q) + (PX_W+1)'(64'd1 << (PX_SH - 1));
    sumy = (PY_W+1)'(prody_q) + (PY_W+1)'(64'd1 << (PY_SH - 1));
    pxf  = sumx[PX_W:PX_SH];
    pyf  = sumy[PY_W:PY_SH];
    out_next.px  = (pxf > PXF_W'(OUT_MAX)) ? OUT_MAX : pxf[OUT_W-1:0];
    out_next.py  = (pyf > PYF_W'(OUT_MAX)) ? OUT_MAX : pyf[OUT_W-1:0];
    out_next.deg = deg_b_q;
    if (deg_b_q) begin
      out_next.px = '0;
      out_next.py = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_q <= out_next;
    end
  end

  assign pixel.valid      = vld[LAST];
  assign pixel.pixel_x    = out_q.px;
  assign pixel.pixel_y    = out_q.py;
  assign pixel.degenerate = out_q.deg;

endmodule

### hw/rtl/erp_checker.sv
// Port-level checker for equirectangular_projection, bound to the top level.
// Depends on erp_pkg and equirectangular_projection_macros.svh.
`include "equirectangular_projection_macros.svh"

module erp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [erp_pkg::OUT_W-1:0]  pixel_x,
  input logic [erp_pkg::OUT_W-1:0]  pixel_y,
  input logic                       degenerate,
  input logic                       pready
);
  import erp_pkg::*;

  `ERP_ASSERT_IMP(a_ready_when_drained, (!out_valid || out_ready), in_ready)
  `ERP_ASSERT_IMP(a_degenerate_zero, (out_valid && degenerate), (pixel_x == '0 && pixel_y == '0))
  `ERP_ASSERT_NXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(degenerate)))
  `ERP_ASSERT_NXT_NR(a_reset_empties, rst, !out_valid)
  `ERP_ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

bind equirectangular_projection erp_checker u_erp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (bearing.ready),
  .out_valid  (pixel.valid),
  .out_ready  (pixel.ready),
  .pixel_x    (pixel.pixel_x),
  .pixel_y    (pixel.pixel_y),
  .degenerate (pixel.degenerate),
  .pready     (pready)
);
